[rtl/pmtd_pkg.sv]
// ----------------------------------------------------------------------------
// pmtd_pkg
// shared constants, types and size helpers of the page margin trim detector
// ----------------------------------------------------------------------------
package pmtd_pkg;

  localparam int unsigned MAX_DIMENSION = 4096;

  localparam int unsigned SIZE_W  = 13;  // image sizes and crop edges
  localparam int unsigned COUNT_W = 12;  // column and row counters
  localparam int unsigned RGB_W   = 24;
  localparam int unsigned ALPHA_W = 8;
  localparam int unsigned INDEX_W = 2;

  // configuration register indexes
  localparam logic [INDEX_W-1:0] REG_PAPER_RGB    = 2'd0;
  localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [RGB_W-1:0]  PAPER_RGB_RESET    = 24'hFFFFFF;
  localparam logic [SIZE_W-1:0] IMAGE_SIZE_RESET   = 13'd1024;
  localparam logic [SIZE_W-1:0] MAX_SIZE           = SIZE_W'(MAX_DIMENSION);

  // reciprocal constants: floor(x * R >> S) is exact over the used range
  localparam logic [31:0] DIV3_RECIP   = 32'd43691;  // 2^17 / 3, rounded up
  localparam int unsigned DIV3_SHIFT   = 17;
  localparam logic [31:0] DIV100_RECIP = 32'd5243;   // 2^19 / 100, rounded up
  localparam int unsigned DIV100_SHIFT = 19;

  // per-axis limits derived from one size register
  typedef struct packed {
    logic [SIZE_W-1:0] n;          // effective size
    logic [SIZE_W-1:0] third;      // n / 3
    logic [SIZE_W-1:0] two_third;  // 2n / 3
    logic [SIZE_W-1:0] margin;     // n / 100
  } axis_limits_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > MAX_SIZE) begin
      r = MAX_SIZE;
    end else begin
      r = s;
    end
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] div3(input logic [SIZE_W:0] x);
    logic [31:0] p;
    p = 32'(x) * DIV3_RECIP;
    return SIZE_W'(p >> DIV3_SHIFT);
  endfunction

  function automatic logic [SIZE_W-1:0] div100(input logic [SIZE_W-1:0] x);
    logic [31:0] p;
    p = 32'(x) * DIV100_RECIP;
    return SIZE_W'(p >> DIV100_SHIFT);
  endfunction

  function automatic axis_limits_t axis_limits(input logic [SIZE_W-1:0] s);
    axis_limits_t l;
    l.n         = eff_size(s);
    l.third     = div3({1'b0, l.n});
    l.two_third = div3({l.n, 1'b0});
    l.margin    = div100(l.n);
    return l;
  endfunction

endpackage

[rtl/pmtd_axis_edges.sv]
// ----------------------------------------------------------------------------
// pmtd_axis_edges
// crop edges along one axis: clamp to the outer thirds, widen by the margin
// ----------------------------------------------------------------------------
module pmtd_axis_edges (
  input  pmtd_pkg::axis_limits_t          limits,
  input  logic [pmtd_pkg::SIZE_W-1:0]     first,
  input  logic [pmtd_pkg::COUNT_W-1:0]    last,
  input  logic                            seen,
  output logic [pmtd_pkg::SIZE_W-1:0]     low_edge,
  output logic [pmtd_pkg::SIZE_W-1:0]     span
);

  logic [pmtd_pkg::SIZE_W-1:0] lo_raw;
  logic [pmtd_pkg::SIZE_W-1:0] lo_clamp;
  logic [pmtd_pkg::SIZE_W-1:0] hi_raw;
  logic [pmtd_pkg::SIZE_W-1:0] hi_clamp;
  logic [pmtd_pkg::SIZE_W:0]   hi_wide;
  logic [pmtd_pkg::SIZE_W-1:0] hi_edge;

  always_comb begin
    lo_raw   = seen ? first : limits.n;
    hi_raw   = seen ? {1'b0, last} : '0;
    lo_clamp = (lo_raw > limits.third) ? limits.third : lo_raw;
    hi_clamp = (hi_raw < limits.two_third) ? limits.two_third : hi_raw;

    // move out by the margin, floored at zero and capped at the size
    low_edge = (lo_clamp >= limits.margin) ? lo_clamp - limits.margin : '0;
    hi_wide  = {1'b0, hi_clamp} + {1'b0, limits.margin};
    hi_edge  = (hi_wide > {1'b0, limits.n}) ? limits.n
                                             : hi_wide[pmtd_pkg::SIZE_W-1:0];
    span     = hi_edge - low_edge;
  end

endmodule

[rtl/page_margin_trim_detector.sv]
// ----------------------------------------------------------------------------
// page_margin_trim_detector
// bounding box of page content over one raster-order page image
// ----------------------------------------------------------------------------
// Pixels of a page image stream in raster order, one item per pixel, and the
// block counts column and row itself. A pixel is content when its alpha is
// nonzero and its RGB differs from paper_rgb. On the last pixel of each image
// one crop box item comes out (left, top, width, height in pixels) and the
// tracking starts over for the next image. Edges are clamped so the box always
// covers the middle third, then widened by size/100 within the image. A
// zero size register counts as 1 and one above 4096 as 4096. Throughput is one
// pixel per clock while the input is not stalled: a pixel is registered on
// acceptance, and from that input register its tracking update and, for the
// last pixel, the crop arithmetic run into the result register, which holds
// the box valid until it is taken. Input stalls only while a finished box
// waits at the output and another image end is due. Size limits (thirds,
// margin) are registered from the size registers, which are registered from
// the write port, so configuration written while idle passes both registers.
// ----------------------------------------------------------------------------
module page_margin_trim_detector (
  input  logic                            clk,
  input  logic                            rst,

  // configuration write port
  input  logic                            cfg_write,
  input  logic [pmtd_pkg::INDEX_W-1:0]    cfg_index,
  input  logic [pmtd_pkg::RGB_W-1:0]      cfg_data,

  // pixel items
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pmtd_pkg::ALPHA_W-1:0]    pixel_alpha,
  input  logic [pmtd_pkg::RGB_W-1:0]      pixel_rgb,

  // crop box items
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pmtd_pkg::SIZE_W-1:0]     crop_left,
  output logic [pmtd_pkg::SIZE_W-1:0]     crop_top,
  output logic [pmtd_pkg::SIZE_W-1:0]     crop_width,
  output logic [pmtd_pkg::SIZE_W-1:0]     crop_height
);

  // configuration registers
  logic [pmtd_pkg::RGB_W-1:0]  paper_rgb;
  logic [pmtd_pkg::SIZE_W-1:0] image_width;
  logic [pmtd_pkg::SIZE_W-1:0] image_height;

  // derived per-axis limits
  pmtd_pkg::axis_limits_t limits_w;
  pmtd_pkg::axis_limits_t limits_h;

  // input register
  logic                         pix_valid;
  logic [pmtd_pkg::ALPHA_W-1:0] pix_alpha;
  logic [pmtd_pkg::RGB_W-1:0]   pix_rgb;

  // tracking state
  logic [pmtd_pkg::COUNT_W-1:0] column_count;
  logic [pmtd_pkg::COUNT_W-1:0] row_count;
  logic [pmtd_pkg::SIZE_W-1:0]  first_content_column;
  logic [pmtd_pkg::COUNT_W-1:0] last_content_column;
  logic [pmtd_pkg::SIZE_W-1:0]  first_content_row;
  logic [pmtd_pkg::COUNT_W-1:0] last_content_row;
  logic                         content_seen;

  // tracking after the current pixel
  logic                         is_content;
  logic [pmtd_pkg::SIZE_W-1:0]  first_col_next;
  logic [pmtd_pkg::COUNT_W-1:0] last_col_next;
  logic [pmtd_pkg::SIZE_W-1:0]  first_row_next;
  logic [pmtd_pkg::COUNT_W-1:0] last_row_next;
  logic                         seen_next;

  logic row_end;
  logic image_end;
  logic advance;

  logic [pmtd_pkg::SIZE_W-1:0] left_edge;
  logic [pmtd_pkg::SIZE_W-1:0] top_edge;
  logic [pmtd_pkg::SIZE_W-1:0] span_w;
  logic [pmtd_pkg::SIZE_W-1:0] span_h;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      paper_rgb    <= pmtd_pkg::PAPER_RGB_RESET;
      image_width  <= pmtd_pkg::IMAGE_SIZE_RESET;
      image_height <= pmtd_pkg::IMAGE_SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        pmtd_pkg::REG_PAPER_RGB:    paper_rgb    <= cfg_data;
        pmtd_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[pmtd_pkg::SIZE_W-1:0];
        pmtd_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[pmtd_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // thirds and margins, one multiply each, registered
  always_ff @(posedge clk) begin
    limits_w <= pmtd_pkg::axis_limits(image_width);
    limits_h <= pmtd_pkg::axis_limits(image_height);
  end

  // end of row / image from the counters and the effective sizes
  always_comb begin
    row_end   = ({1'b0, column_count} + pmtd_pkg::SIZE_W'(1)) >= limits_w.n;
    image_end = row_end
             && (({1'b0, row_count} + pmtd_pkg::SIZE_W'(1)) >= limits_h.n);
    // a pixel that ends an image needs the result slot free
    advance   = pix_valid && (!image_end || !out_valid || out_ready);
    in_ready  = !pix_valid || advance;
  end

  // running min/max including the current pixel
  always_comb begin
    is_content     = (pix_alpha != '0) && (pix_rgb != paper_rgb);
    first_col_next = first_content_column;
    last_col_next  = last_content_column;
    first_row_next = first_content_row;
    last_row_next  = last_content_row;
    if (is_content) begin
      if (!content_seen || ({1'b0, column_count} < first_content_column)) begin
        first_col_next = {1'b0, column_count};
      end
      if (!content_seen || (column_count > last_content_column)) begin
        last_col_next = column_count;
      end
      if (!content_seen) begin
        first_row_next = {1'b0, row_count};
      end
      last_row_next = row_count;
    end
    seen_next = content_seen || is_content;
  end

  pmtd_axis_edges u_edges_x (
    .limits   (limits_w),
    .first    (first_col_next),
    .last     (last_col_next),
    .seen     (seen_next),
    .low_edge (left_edge),
    .span     (span_w)
  );

  pmtd_axis_edges u_edges_y (
    .limits   (limits_h),
    .first    (first_row_next),
    .last     (last_row_next),
    .seen     (seen_next),
    .low_edge (top_edge),
    .span     (span_h)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (in_ready) begin
      pix_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pix_alpha <= pixel_alpha;
      pix_rgb   <= pixel_rgb;
    end
  end

  // tracking state and raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count         <= '0;
      row_count            <= '0;
      first_content_column <= '1;
      last_content_column  <= '0;
      first_content_row    <= '1;
      last_content_row     <= '0;
      content_seen         <= 1'b0;
    end else if (advance) begin
      if (image_end) begin
        column_count         <= '0;
        row_count            <= '0;
        first_content_column <= '1;
        last_content_column  <= '0;
        first_content_row    <= '1;
        last_content_row     <= '0;
        content_seen         <= 1'b0;
      end else begin
        first_content_column <= first_col_next;
        last_content_column  <= last_col_next;
        first_content_row    <= first_row_next;
        last_content_row     <= last_row_next;
        content_seen         <= seen_next;
        if (row_end) begin
          column_count <= '0;
          row_count    <= row_count + pmtd_pkg::COUNT_W'(1);
        end else begin
          column_count <= column_count + pmtd_pkg::COUNT_W'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && image_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && image_end) begin
      crop_left   <= left_edge;
      crop_top    <= top_edge;
      crop_width  <= span_w;
      crop_height <= span_h;
    end
  end

  // a finished image always leaves a box at the output
  a_box_on_image_end: assert property (@(posedge clk) disable iff (rst)
    advance && image_end |=> out_valid)
    else $error("image end did not load a crop box");

  // tracking is cleared only at an image end
  a_seen_holds: assert property (@(posedge clk) disable iff (rst)
    content_seen && !(advance && image_end) |=> content_seen)
    else $error("content flag dropped before image end");

  // once content is seen the column range is ordered
  a_column_order: assert property (@(posedge clk) disable iff (rst)
    content_seen |-> first_content_column <= {1'b0, last_content_column})
    else $error("first content column past last content column");

  // a held pixel is not lost
  a_pixel_held: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !advance |=> pix_valid && $stable(pix_rgb) && $stable(pix_alpha))
    else $error("stalled pixel changed");

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the page margin trim detector
// ----------------------------------------------------------------------------
// Pixel items go in through a paced valid/ready sender. Each accepted pixel is
// run through a bit-accurate tracker kept here. On each image end the tracker
// queues the crop box it expects. A checker pops and compares each crop box
// item that the block hands out. Directed tests cover paper detection, one
// pixel images, resizing inside an image and the size extremes. Random phases
// then vary the paper color, the image sizes and the pacing on both sides.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [pmtd_pkg::INDEX_W-1:0] REG_UNUSED = 2'd3;  // no register behind it
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned DRAIN_CYCLES = 4;           // pipeline depth plus slack
  localparam int unsigned WIDE_RUN = 120;             // pixels into a 4096 wide row
  localparam int unsigned TALL_RUN = 80;              // rows into a 4096 tall image

  typedef struct packed {
    logic [pmtd_pkg::SIZE_W-1:0] left;
    logic [pmtd_pkg::SIZE_W-1:0] top;
    logic [pmtd_pkg::SIZE_W-1:0] width;
    logic [pmtd_pkg::SIZE_W-1:0] height;
  } crop_box_t;

  typedef struct packed {
    logic [pmtd_pkg::SIZE_W-1:0] lo;
    logic [pmtd_pkg::SIZE_W-1:0] hi;
  } span_t;

  // dut ports, all inputs known from time zero
  logic                           clk;
  logic                           rst = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [pmtd_pkg::INDEX_W-1:0]   cfg_index = '0;
  logic [pmtd_pkg::RGB_W-1:0]     cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [pmtd_pkg::ALPHA_W-1:0]   pixel_alpha = '0;
  logic [pmtd_pkg::RGB_W-1:0]     pixel_rgb = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [pmtd_pkg::SIZE_W-1:0]    crop_left;
  logic [pmtd_pkg::SIZE_W-1:0]    crop_top;
  logic [pmtd_pkg::SIZE_W-1:0]    crop_width;
  logic [pmtd_pkg::SIZE_W-1:0]    crop_height;

  // pacing knobs, in percent of cycles
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // bookkeeping
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned boxes_checked = 0;
  int unsigned writes_done = 0;

  // crop boxes predicted but not yet seen at the output
  crop_box_t boxes_due[$];

  // tracker copy of the registers and the scan state
  logic [pmtd_pkg::RGB_W-1:0]   paper_color;
  logic [pmtd_pkg::SIZE_W-1:0]  width_reg;
  logic [pmtd_pkg::SIZE_W-1:0]  height_reg;
  logic [pmtd_pkg::COUNT_W-1:0] col_at;
  logic [pmtd_pkg::COUNT_W-1:0] row_at;
  logic [pmtd_pkg::SIZE_W-1:0]  first_col;
  logic [pmtd_pkg::COUNT_W-1:0] last_col;
  logic [pmtd_pkg::SIZE_W-1:0]  first_row;
  logic [pmtd_pkg::COUNT_W-1:0] last_row;
  bit                           content_found;
  bit                           image_closed;  // last tracked pixel ended an image

  page_margin_trim_detector u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_alpha (pixel_alpha),
    .pixel_rgb   (pixel_rgb),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .crop_left   (crop_left),
    .crop_top    (crop_top),
    .crop_width  (crop_width),
    .crop_height (crop_height)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit, far above the slowest legal run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d crop boxes still due", cycle_count,
               boxes_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stalls at the rate of the current phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // tracker
  // ---------------------------------------------------------------------------

  // zero counts as one, anything past the maximum as the maximum
  function automatic int unsigned effective_size(input logic [pmtd_pkg::SIZE_W-1:0] s);
    if (s == '0) return 1;
    if (s > pmtd_pkg::MAX_DIMENSION) return pmtd_pkg::MAX_DIMENSION;
    return 32'(s);
  endfunction

  // low and high edge of one axis: cover the middle third, widen by n/100
  function automatic span_t axis_edges(input int unsigned n, input int unsigned first,
                                       input int unsigned last, input bit seen);
    int unsigned lo;
    int unsigned hi;
    int unsigned margin;
    span_t s;
    lo = seen ? first : n;
    hi = seen ? last : 0;
    margin = n / 100;
    if (lo > n / 3) lo = n / 3;
    if (hi < (2 * n) / 3) hi = (2 * n) / 3;
    lo = (lo >= margin) ? lo - margin : 0;
    hi = hi + margin;
    if (hi > n) hi = n;
    s.lo = pmtd_pkg::SIZE_W'(lo);
    s.hi = pmtd_pkg::SIZE_W'(hi);
    return s;
  endfunction

  task automatic clear_scan();
    col_at = '0;
    row_at = '0;
    first_col = '1;
    last_col = '0;
    first_row = '1;
    last_row = '0;
    content_found = 1'b0;
  endtask

  task automatic reset_tracker();
    paper_color = pmtd_pkg::PAPER_RGB_RESET;
    width_reg = pmtd_pkg::IMAGE_SIZE_RESET;
    height_reg = pmtd_pkg::IMAGE_SIZE_RESET;
    image_closed = 1'b0;
    clear_scan();
  endtask

  // advance the scan by one accepted pixel, queue a box on image end
  task automatic track_pixel(input logic [pmtd_pkg::ALPHA_W-1:0] alpha,
                             input logic [pmtd_pkg::RGB_W-1:0] rgb);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned row;
    bit row_end;
    span_t xs;
    span_t ys;
    crop_box_t box;
    w = effective_size(width_reg);
    h = effective_size(height_reg);
    col = 32'(col_at);
    row = 32'(row_at);
    // a counter at or past a shrunken size still ends the row or image
    row_end = (col + 1 >= w);
    image_closed = row_end && (row + 1 >= h);
    if (alpha != '0 && rgb != paper_color) begin
      if (!content_found || col_at < first_col) first_col = {1'b0, col_at};
      if (!content_found || col_at > last_col) last_col = col_at;
      if (!content_found) first_row = {1'b0, row_at};
      last_row = row_at;
      content_found = 1'b1;
    end
    if (image_closed) begin
      xs = axis_edges(w, 32'(first_col), 32'(last_col), content_found);
      ys = axis_edges(h, 32'(first_row), 32'(last_row), content_found);
      box.left = xs.lo;
      box.top = ys.lo;
      box.width = xs.hi - xs.lo;
      box.height = ys.hi - ys.lo;
      boxes_due.push_back(box);
      clear_scan();
    end else if (row_end) begin
      col_at = '0;
      row_at = row_at + 1'b1;
    end else begin
      col_at = col_at + 1'b1;
    end
  endtask

  function automatic bit image_in_progress();
    return (col_at != '0 || row_at != '0);
  endfunction

  // ---------------------------------------------------------------------------
  // checker
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [pmtd_pkg::SIZE_W-1:0] expv,
                             input logic [pmtd_pkg::SIZE_W-1:0] actv);
    if (expv !== actv) begin
      $display("@%0t crop box %0d %s: expected %0d, got %0d", $time, boxes_checked,
               name, expv, actv);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    crop_box_t want;
    if (!rst && out_valid && out_ready) begin
      if (boxes_due.size() == 0) begin
        $display("@%0t crop box with none due: expected nothing, got %0d %0d %0d %0d",
                 $time, crop_left, crop_top, crop_width, crop_height);
        error_count++;
      end else begin
        want = boxes_due.pop_front();
        check_field("left", want.left, crop_left);
        check_field("top", want.top, crop_top);
        check_field("width", want.width, crop_width);
        check_field("height", want.height, crop_height);
      end
      boxes_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one pixel item: optional idle gap, then hold valid until accepted
  task automatic send_pixel(input logic [pmtd_pkg::ALPHA_W-1:0] alpha,
                            input logic [pmtd_pkg::RGB_W-1:0] rgb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_alpha <= alpha;
    pixel_rgb <= rgb;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
    track_pixel(alpha, rgb);
  endtask

  // mostly paper, some transparent, content at the given rate
  task automatic send_random_pixel(input int unsigned content_pct);
    logic [pmtd_pkg::ALPHA_W-1:0] alpha;
    logic [pmtd_pkg::RGB_W-1:0] rgb;
    alpha = pmtd_pkg::ALPHA_W'($urandom_range(1, 255));
    if ($urandom_range(99) < content_pct) begin
      if ($urandom_range(1)) begin
        rgb = pmtd_pkg::RGB_W'($urandom);
      end else begin
        // one bit away from paper still counts as content
        rgb = paper_color ^ (pmtd_pkg::RGB_W'(1) << $urandom_range(pmtd_pkg::RGB_W - 1));
      end
    end else if ($urandom_range(2) == 0) begin
      // transparent pixel of any color is paper
      alpha = '0;
      rgb = pmtd_pkg::RGB_W'($urandom);
    end else begin
      rgb = paper_color;
    end
    send_pixel(alpha, rgb);
  endtask

  // stop sending and let every due box and the pipeline drain
  task automatic drain_results();
    in_valid <= 1'b0;
    while (boxes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write enable stays high across back-to-back writes
  task automatic write_register(input logic [pmtd_pkg::INDEX_W-1:0] idx,
                                input logic [pmtd_pkg::RGB_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    writes_done++;
    case (idx)
      pmtd_pkg::REG_PAPER_RGB:    paper_color = data;
      pmtd_pkg::REG_IMAGE_WIDTH:  width_reg = data[pmtd_pkg::SIZE_W-1:0];
      pmtd_pkg::REG_IMAGE_HEIGHT: height_reg = data[pmtd_pkg::SIZE_W-1:0];
      default: ;
    endcase
  endtask

  // size limits are registered inside, give them time to settle
  task automatic end_writes();
    cfg_write <= 1'b0;
    repeat (3) @(posedge clk);
  endtask

  // size word, sometimes with junk above the register width
  function automatic logic [pmtd_pkg::RGB_W-1:0] size_word(input int unsigned s);
    if ($urandom_range(3) == 0) return {11'($urandom), pmtd_pkg::SIZE_W'(s)};
    return pmtd_pkg::RGB_W'(s);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // alpha and color rules on a 3x2 page, black paper then white paper
  task automatic test_paper_detection();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_results();
    write_register(pmtd_pkg::REG_PAPER_RGB, 24'h000000);
    write_register(pmtd_pkg::REG_IMAGE_WIDTH, 24'd3);
    write_register(pmtd_pkg::REG_IMAGE_HEIGHT, 24'd2);
    end_writes();
    // no content at all: box falls back to the middle third
    send_pixel(8'hFF, 24'h000000);
    send_pixel(8'h00, 24'hFFFFFF);
    send_pixel(8'hFF, 24'h000000);
    send_pixel(8'h00, 24'h000000);
    send_pixel(8'h80, 24'h000000);
    send_pixel(8'hFF, 24'h000000);
    drain_results();
    write_register(pmtd_pkg::REG_PAPER_RGB, 24'hFFFFFF);
    end_writes();
    // content on the first and the last pixel only
    send_pixel(8'h01, 24'hFFFFFE);
    send_pixel(8'hFF, 24'hFFFFFF);
    send_pixel(8'h00, 24'h123456);
    send_pixel(8'hFF, 24'hFFFFFF);
    send_pixel(8'hFF, 24'hFFFFFF);
    send_pixel(8'hFF, 24'h000000);
  endtask

  // 1x1 images end on every pixel; a write to the spare index does nothing
  task automatic test_single_pixel_images();
    drain_results();
    write_register(REG_UNUSED, 24'hFFFFFF);
    write_register(pmtd_pkg::REG_IMAGE_WIDTH, 24'd1);
    write_register(pmtd_pkg::REG_IMAGE_HEIGHT, 24'd1);
    end_writes();
    send_pixel(8'hFF, 24'h7FFFFF);
    send_pixel(8'h00, 24'h000000);
  endtask

  // counters survive a size change in the middle of an image
  task automatic test_mid_image_resize();
    drain_results();
    write_register(pmtd_pkg::REG_IMAGE_WIDTH, 24'd4);
    write_register(pmtd_pkg::REG_IMAGE_HEIGHT, 24'd3);
    end_writes();
    send_pixel(8'hFF, 24'hFFFFFF);
    send_pixel(8'hC8, 24'h00FF00);
    send_pixel(8'hFF, 24'hFFFFFF);
    // column 3 now lies past the new width and closes the row
    drain_results();
    write_register(pmtd_pkg::REG_IMAGE_WIDTH, 24'd2);
    end_writes();
    send_pixel(8'hFF, 24'h0000FF);
    send_pixel(8'hFF, 24'hFFFFFF);
    // row 1 now lies past the new height and closes the image
    drain_results();
    write_register(pmtd_pkg::REG_IMAGE_HEIGHT, 24'd1);
    end_writes();
    send_pixel(8'h11, 24'hFF0000);
  endtask

  // a full-size width and an oversize height, each with the other axis at zero;
  // the long axis is cut short by a shrink that closes the image at once
  task automatic test_extreme_sizes();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_results();
    write_register(pmtd_pkg::REG_IMAGE_WIDTH, 24'd4096);
    write_register(pmtd_pkg::REG_IMAGE_HEIGHT, 24'd0);
    end_writes();
    repeat (WIDE_RUN) send_random_pixel(1);
    drain_results();
    write_register(pmtd_pkg::REG_IMAGE_WIDTH, 24'd100);
    end_writes();
    do send_random_pixel(1); while (!image_closed);
    drain_results();
    write_register(pmtd_pkg::REG_IMAGE_WIDTH, 24'd0);
    write_register(pmtd_pkg::REG_IMAGE_HEIGHT, 24'hFFFFFF);
    end_writes();
    repeat (TALL_RUN) send_random_pixel(1);
    drain_results();
    write_register(pmtd_pkg::REG_IMAGE_HEIGHT, 24'd0);
    end_writes();
    do send_random_pixel(1); while (!image_closed);
  endtask

  // groups of pixels under random setups; most groups stop on an image end
  task automatic test_random_stream(input int unsigned send_pct, input int unsigned recv_pct,
                                    input int unsigned budget);
    int unsigned start;
    int unsigned group_start;
    int unsigned group_len;
    int unsigned content_pct;
    int unsigned shape;
    int unsigned w;
    int unsigned h;
    int unsigned swap;
    bit whole;
    logic [pmtd_pkg::RGB_W-1:0] paper;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    start = pixels_sent;
    while (pixels_sent - start < budget) begin
      case ($urandom_range(9))
        0:       paper = 24'h000000;
        1:       paper = 24'hFFFFFF;
        default: paper = pmtd_pkg::RGB_W'($urandom);
      endcase
      shape = $urandom_range(19);
      if (shape == 0) begin
        // long strip, wide enough for a nonzero margin
        w = $urandom_range(100, 200);
        h = 1;
        if ($urandom_range(1)) begin
          swap = w;
          w = h;
          h = swap;
        end
      end else if (shape == 1) begin
        w = 0;
        h = $urandom_range(0, 5);
      end else if (shape == 2) begin
        w = $urandom_range(1, 6);
        h = 0;
      end else begin
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 6);
      end
      // open image, if any, carries over into the new setup
      drain_results();
      write_register(pmtd_pkg::REG_PAPER_RGB, paper);
      write_register(pmtd_pkg::REG_IMAGE_WIDTH, size_word(w));
      write_register(pmtd_pkg::REG_IMAGE_HEIGHT, size_word(h));
      end_writes();
      group_len = $urandom_range(30, 90);
      content_pct = $urandom_range(2, 60);
      whole = ($urandom_range(3) != 0);
      group_start = pixels_sent;
      while (pixels_sent - group_start < group_len || (whole && image_in_progress()))
        send_random_pixel(content_pct);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned waited;
    reset_tracker();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_paper_detection();
    test_single_pixel_images();
    test_mid_image_resize();
    test_extreme_sizes();
    test_random_stream(0, 0, 150);
    test_random_stream(83, 0, 150);
    test_random_stream(0, 83, 150);
    test_random_stream(20, 20, 150);
    // close the last image so its box comes out
    while (image_in_progress()) send_random_pixel(10);

    // wait for the due boxes, then watch a little longer for stray ones
    in_valid <= 1'b0;
    waited = 0;
    while (boxes_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (boxes_due.size() != 0) begin
      $display("@%0t %0d crop boxes expected but never seen", $time, boxes_due.size());
      error_count += boxes_due.size();
    end

    $display("run: %0d pixels, %0d crop boxes compared, %0d register writes, %0d errors",
             pixels_sent, boxes_checked, writes_done, error_count);
    $display("run: paper extremes, size registers at 0, 1, 4096 and oversize, %s",
             "resizes inside images, 4 pacings");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
